>>> rtl/core/ict_pkg.sv
package ict_pkg;

    localparam int unsigned LINE_FIELD_BITS   = 20;
    localparam int unsigned COLUMN_FIELD_BITS = 16;

    localparam logic [3:0] PH_EXP_NAME  = 4'd0;
    localparam logic [3:0] PH_SECTION   = 4'd1;
    localparam logic [3:0] PH_NAME      = 4'd2;
    localparam logic [3:0] PH_COMMENT   = 4'd3;
    localparam logic [3:0] PH_EXP_EQ    = 4'd4;
    localparam logic [3:0] PH_EXP_VALUE = 4'd5;
    localparam logic [3:0] PH_VALUE     = 4'd6;
    localparam logic [3:0] PH_QUOTED    = 4'd7;
    localparam logic [3:0] PH_EXP_EOL   = 4'd8;

    localparam logic [3:0] EV_NONE       = 4'd0;
    localparam logic [3:0] EV_SEC_OPEN   = 4'd1;
    localparam logic [3:0] EV_SEC_CHAR   = 4'd2;
    localparam logic [3:0] EV_NAME_FIRST = 4'd3;
    localparam logic [3:0] EV_NAME_CHAR  = 4'd4;
    localparam logic [3:0] EV_VAL_FIRST  = 4'd5;
    localparam logic [3:0] EV_QUOTE_OPEN = 4'd6;
    localparam logic [3:0] EV_VAL_CHAR   = 4'd7;
    localparam logic [3:0] EV_COMMIT     = 4'd8;
    localparam logic [3:0] EV_ERROR      = 4'd9;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_NAME_EXP     = 3'd1;
    localparam logic [2:0] ERR_BRACKET_EXP  = 3'd2;
    localparam logic [2:0] ERR_EQUALS_EXP   = 3'd3;
    localparam logic [2:0] ERR_VALUE_EXP    = 3'd4;
    localparam logic [2:0] ERR_EOL_EXP      = 3'd5;
    localparam logic [2:0] ERR_OPEN_QUOTE   = 3'd6;

    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_OPEN   = 8'h5B;
    localparam logic [7:0] CH_CLOSE  = 8'h5D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_ESC    = 8'h5C;
    localparam logic [7:0] CH_EOL    = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [3:0] {
        K_SPACE, K_DIGIT, K_ALPHA, K_DASH, K_EQ, K_QUOTE, K_OPEN, K_CLOSE,
        K_HASH, K_ESC, K_EOL, K_OTHER
    } char_class_t;

    typedef struct packed {
        logic [COLUMN_FIELD_BITS-1:0] column_number;
        logic [LINE_FIELD_BITS-1:0]   line_number;
        logic [2:0]                   error_code;
        logic [7:0]                   out_byte;
        logic [3:0]                   event_res;
    } result_t;

    function automatic char_class_t classify(input logic [7:0] b);
        char_class_t k;
        k = K_OTHER;
        if (b == CH_EOL) begin
            k = K_EOL;
        end else if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
            k = K_SPACE;
        end else if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A)) begin
            k = K_ALPHA;
        end else if (b >= 8'h30 && b <= 8'h39) begin
            k = K_DIGIT;
        end else if (b == CH_DASH || b == CH_UNDER) begin
            k = K_DASH;
        end else if (b == CH_EQ) begin
            k = K_EQ;
        end else if (b == CH_QUOTE) begin
            k = K_QUOTE;
        end else if (b == CH_OPEN) begin
            k = K_OPEN;
        end else if (b == CH_CLOSE) begin
            k = K_CLOSE;
        end else if (b == CH_HASH) begin
            k = K_HASH;
        end else if (b == CH_ESC) begin
            k = K_ESC;
        end
        return k;
    endfunction

endpackage

>>> rtl/core/ini_config_tokenizer_core.sv
// Channel  Dir  Word                                             Last / user
// s_       in   tdata[7:0] byte_in                               tlast end_of_stream
// m_       out  tdata[7:0] out_byte, [10:8] error_code,          tuser[3:0] event_res
//               [30:11] line_number, [46:31] column_number
//
// Each result is registered at the edge that accepts its word; a new word can
// be accepted in every cycle while the skid register is empty.
// A two-entry output stage (output register plus skid register) keeps the
// input side open for one word while the output side stalls.
// Reset is synchronous and active low; it returns the parser to the state
// that expects an item name, with line 1 and column 0.
module ini_config_tokenizer_core
    import ict_pkg::*;
#(
    parameter int unsigned LINE_BITS   = 20,
    parameter int unsigned COLUMN_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tlast,   // end_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_byte, error_code, line_number, column_number
    output logic [3:0]  m_tuser    // event_res
);

    logic [3:0]             phase_reg, phase_next;
    logic                   escape_reg, escape_next;
    logic                   halted_reg, halted_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] column_reg, column_next;

    result_t out_reg, out_next;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    accept;

    logic [COLUMN_BITS-1:0] column_inc;
    logic [32:0]            line_wide;
    logic [32:0]            column_wide;
    char_class_t            k;
    logic [3:0]             ev;
    logic [7:0]             ob;
    logic [2:0]             code;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !skid_valid_reg;

    always_comb begin
        phase_next  = phase_reg;
        escape_next = escape_reg;
        halted_next = halted_reg;
        line_next   = line_reg;
        column_next = column_reg;
        ev          = EV_NONE;
        ob          = 8'd0;
        code        = ERR_NONE;
        k           = classify(s_tdata);
        column_inc  = (column_reg != '1) ? column_reg + 1'b1 : column_reg;

        line_wide   = {{(33 - LINE_BITS){1'b0}}, line_reg};
        column_wide = {{(33 - COLUMN_BITS){1'b0}}, column_reg};

        if (s_tlast) begin
            if (!halted_reg) begin
                if (phase_reg == PH_QUOTED) begin
                    ev   = EV_ERROR;
                    code = ERR_OPEN_QUOTE;
                end else if (phase_reg == PH_VALUE) begin
                    ev = EV_COMMIT;
                end
            end
            phase_next  = PH_EXP_NAME;
            escape_next = 1'b0;
            halted_next = 1'b0;
            line_next   = LINE_BITS'(1);
            column_next = '0;
        end else if (!halted_reg) begin
            column_wide = {{(33 - COLUMN_BITS){1'b0}}, column_inc};
            column_next = column_inc;
            case (phase_reg)
                PH_EXP_NAME: begin
                    if (k == K_ALPHA || k == K_DIGIT || k == K_DASH) begin
                        phase_next = PH_NAME;
                        ev         = EV_NAME_FIRST;
                        ob         = s_tdata;
                    end else if (k == K_OPEN) begin
                        phase_next = PH_SECTION;
                        ev         = EV_SEC_OPEN;
                    end else if (k == K_HASH) begin
                        phase_next = PH_COMMENT;
                    end else if (k != K_SPACE && k != K_EOL) begin
                        ev   = EV_ERROR;
                        code = ERR_NAME_EXP;
                    end
                end
                PH_SECTION: begin
                    if (k == K_ALPHA || k == K_DIGIT) begin
                        ev = EV_SEC_CHAR;
                        ob = s_tdata;
                    end else if (k == K_CLOSE) begin
                        phase_next = PH_EXP_EOL;
                    end else begin
                        ev   = EV_ERROR;
                        code = ERR_BRACKET_EXP;
                    end
                end
                PH_NAME: begin
                    if (k == K_ALPHA || k == K_DIGIT || k == K_DASH) begin
                        ev = EV_NAME_CHAR;
                        ob = s_tdata;
                    end else if (k == K_EQ) begin
                        phase_next = PH_EXP_VALUE;
                    end else if (k == K_SPACE) begin
                        phase_next = PH_EXP_EQ;
                    end else begin
                        ev   = EV_ERROR;
                        code = ERR_EQUALS_EXP;
                    end
                end
                PH_COMMENT: begin
                    if (k == K_EOL) begin
                        phase_next = PH_EXP_NAME;
                    end
                end
                PH_EXP_EQ: begin
                    if (k == K_EQ) begin
                        phase_next = PH_EXP_VALUE;
                    end else if (k != K_SPACE) begin
                        ev   = EV_ERROR;
                        code = ERR_EQUALS_EXP;
                    end
                end
                PH_EXP_VALUE: begin
                    if (k == K_ALPHA || k == K_DIGIT || k == K_DASH) begin
                        phase_next = PH_VALUE;
                        ev         = EV_VAL_FIRST;
                        ob         = s_tdata;
                    end else if (k == K_QUOTE) begin
                        phase_next = PH_QUOTED;
                        ev         = EV_QUOTE_OPEN;
                    end else if (k != K_SPACE) begin
                        ev   = EV_ERROR;
                        code = ERR_VALUE_EXP;
                    end
                end
                PH_VALUE: begin
                    if (k == K_QUOTE) begin
                        ev   = EV_ERROR;
                        code = ERR_VALUE_EXP;
                    end else if (k == K_SPACE) begin
                        phase_next = PH_EXP_EOL;
                        ev         = EV_COMMIT;
                    end else if (k == K_EOL) begin
                        phase_next = PH_EXP_NAME;
                        ev         = EV_COMMIT;
                    end else if (k == K_HASH) begin
                        phase_next = PH_COMMENT;
                        ev         = EV_COMMIT;
                    end else begin
                        ev = EV_VAL_CHAR;
                        ob = s_tdata;
                    end
                end
                PH_QUOTED: begin
                    if (escape_reg) begin
                        escape_next = 1'b0;
                        ev          = EV_VAL_CHAR;
                        ob          = s_tdata;
                    end else if (k == K_QUOTE) begin
                        phase_next = PH_EXP_EOL;
                        ev         = EV_COMMIT;
                    end else if (k == K_ESC) begin
                        escape_next = 1'b1;
                    end else begin
                        ev = EV_VAL_CHAR;
                        ob = s_tdata;
                    end
                end
                PH_EXP_EOL: begin
                    if (k == K_HASH) begin
                        phase_next = PH_COMMENT;
                    end else if (k == K_EOL) begin
                        phase_next = PH_EXP_NAME;
                    end else if (k != K_SPACE) begin
                        ev   = EV_ERROR;
                        code = ERR_EOL_EXP;
                    end
                end
                default: begin
                    phase_next = PH_EXP_NAME;
                end
            endcase

            if (ev == EV_ERROR) begin
                halted_next = 1'b1;
            end else if (s_tdata == CH_EOL) begin
                if (line_reg != '1) begin
                    line_next = line_reg + 1'b1;
                end
                column_next = '0;
            end
        end

        out_next.event_res  = ev;
        out_next.out_byte   = ob;
        out_next.error_code = code;
        out_next.line_number = (line_wide > 33'((1 << LINE_FIELD_BITS) - 1))
                             ? '1 : line_wide[LINE_FIELD_BITS-1:0];
        out_next.column_number = (column_wide > 33'((1 << COLUMN_FIELD_BITS) - 1))
                               ? '1 : column_wide[COLUMN_FIELD_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_EXP_NAME;
            escape_reg <= 1'b0;
            halted_reg <= 1'b0;
            line_reg   <= LINE_BITS'(1);
            column_reg <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            escape_reg <= escape_next;
            halted_reg <= halted_next;
            line_reg   <= line_next;
            column_reg <= column_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (accept) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (!out_valid_reg || m_tready) begin
                out_reg <= out_next;
            end else begin
                skid_reg <= out_next;
            end
        end else if (m_tready && skid_valid_reg) begin
            out_reg <= skid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tdata  = {1'b0, out_reg.column_number, out_reg.line_number,
                       out_reg.error_code, out_reg.out_byte};

endmodule

>>> rtl/core/ict_checker.sv
module ict_checker
    import ict_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [3:0]  m_tuser
);

    logic [7:0] obyte;
    logic [2:0] ecode;

    assign obyte = m_tdata[7:0];
    assign ecode = m_tdata[10:8];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled output word changed.");

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_ERROR |-> ecode != ERR_NONE)
        else $error("Error word without an error code.");

    a_no_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != EV_ERROR |-> ecode == ERR_NONE)
        else $error("Error code on a word that is not an error.");

    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == EV_NONE || m_tuser == EV_SEC_OPEN ||
        m_tuser == EV_QUOTE_OPEN || m_tuser == EV_COMMIT || m_tuser == EV_ERROR)
        |-> obyte == 8'd0)
        else $error("Byte carried on an event that appends nothing.");

    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[30:11] != 20'd0)
        else $error("Line number reported as zero.");

endmodule

bind ini_config_tokenizer_core ict_checker u_ict_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> test/tb_ini_config_tokenizer_core.sv
`timescale 1ns / 1ps

module tb_ini_config_tokenizer_core;
    import ict_pkg::*;

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam logic [LINE_FIELD_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_FIELD_BITS-1:0] COL_MAX  = '1;
    localparam int unsigned RANDOM_WORDS = 800;

    typedef struct {
        logic [7:0] b;
        logic       eos;
        bit         fixed;
        result_t    res;
    } step_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [3:0]  m_tuser;

    logic [3:0]                   parse_state;
    bit                           escape_q;
    bit                           halt_q;
    logic [LINE_FIELD_BITS-1:0]   line_q;
    logic [COLUMN_FIELD_BITS-1:0] col_q;

    result_t     expected_tokens[$];
    step_row_t   directed_steps[$];
    int unsigned fail_count  = 0;
    int unsigned live_words  = 0;
    int unsigned noise_pct   = 0;
    bit          steady_run  = 1'b0;

    ini_config_tokenizer_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic result_t token_word(input logic [3:0] ev, input logic [7:0] ob,
                                           input logic [2:0] code,
                                           input logic [LINE_FIELD_BITS-1:0] ln,
                                           input logic [COLUMN_FIELD_BITS-1:0] col);
        result_t r;
        r.event_res     = ev;
        r.out_byte      = ob;
        r.error_code    = code;
        r.line_number   = ln;
        r.column_number = col;
        return r;
    endfunction

    function automatic char_class_t byte_kind(input logic [7:0] b);
        char_class_t k;
        case (b)
            CH_EOL: k = K_EOL;
            CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR: k = K_SPACE;
            CH_DASH, CH_UNDER: k = K_DASH;
            CH_EQ: k = K_EQ;
            CH_QUOTE: k = K_QUOTE;
            CH_OPEN: k = K_OPEN;
            CH_CLOSE: k = K_CLOSE;
            CH_HASH: k = K_HASH;
            CH_ESC: k = K_ESC;
            default: begin
                if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) begin
                    k = K_ALPHA;
                end else if (b >= "0" && b <= "9") begin
                    k = K_DIGIT;
                end else begin
                    k = K_OTHER;
                end
            end
        endcase
        return k;
    endfunction

    function automatic bit is_word(input char_class_t k);
        return k == K_ALPHA || k == K_DIGIT || k == K_DASH;
    endfunction

    function automatic result_t tokenize_byte(input logic [7:0] b, input logic eos);
        char_class_t k;
        logic [3:0]  ev;
        logic [7:0]  ob;
        logic [2:0]  code;
        result_t     r;
        ev   = EV_NONE;
        ob   = 8'h00;
        code = ERR_NONE;
        if (eos) begin
            if (!halt_q && parse_state == PH_QUOTED) begin
                ev   = EV_ERROR;
                code = ERR_OPEN_QUOTE;
            end else if (!halt_q && parse_state == PH_VALUE) begin
                ev = EV_COMMIT;
            end
            r = token_word(ev, 8'h00, code, line_q, col_q);
            parse_state = PH_EXP_NAME;
            escape_q    = 1'b0;
            halt_q      = 1'b0;
            line_q      = LINE_FIELD_BITS'(1);
            col_q       = '0;
            return r;
        end
        if (halt_q) begin
            return token_word(EV_NONE, 8'h00, ERR_NONE, line_q, col_q);
        end
        if (col_q < COL_MAX) begin
            col_q = col_q + 1'b1;
        end
        k = byte_kind(b);
        case (parse_state)
            PH_EXP_NAME: begin
                if (is_word(k)) begin
                    parse_state = PH_NAME;
                    ev = EV_NAME_FIRST;
                    ob = b;
                end else if (k == K_OPEN) begin
                    parse_state = PH_SECTION;
                    ev = EV_SEC_OPEN;
                end else if (k == K_HASH) begin
                    parse_state = PH_COMMENT;
                end else if (k != K_SPACE && k != K_EOL) begin
                    ev = EV_ERROR;
                    code = ERR_NAME_EXP;
                end
            end
            PH_SECTION: begin
                if (k == K_ALPHA || k == K_DIGIT) begin
                    ev = EV_SEC_CHAR;
                    ob = b;
                end else if (k == K_CLOSE) begin
                    parse_state = PH_EXP_EOL;
                end else begin
                    ev = EV_ERROR;
                    code = ERR_BRACKET_EXP;
                end
            end
            PH_NAME: begin
                if (is_word(k)) begin
                    ev = EV_NAME_CHAR;
                    ob = b;
                end else if (k == K_EQ) begin
                    parse_state = PH_EXP_VALUE;
                end else if (k == K_SPACE) begin
                    parse_state = PH_EXP_EQ;
                end else begin
                    ev = EV_ERROR;
                    code = ERR_EQUALS_EXP;
                end
            end
            PH_COMMENT: begin
                if (k == K_EOL) begin
                    parse_state = PH_EXP_NAME;
                end
            end
            PH_EXP_EQ: begin
                if (k == K_EQ) begin
                    parse_state = PH_EXP_VALUE;
                end else if (k != K_SPACE) begin
                    ev = EV_ERROR;
                    code = ERR_EQUALS_EXP;
                end
            end
            PH_EXP_VALUE: begin
                if (is_word(k)) begin
                    parse_state = PH_VALUE;
                    ev = EV_VAL_FIRST;
                    ob = b;
                end else if (k == K_QUOTE) begin
                    parse_state = PH_QUOTED;
                    ev = EV_QUOTE_OPEN;
                end else if (k != K_SPACE) begin
                    ev = EV_ERROR;
                    code = ERR_VALUE_EXP;
                end
            end
            PH_VALUE: begin
                if (k == K_QUOTE) begin
                    ev = EV_ERROR;
                    code = ERR_VALUE_EXP;
                end else if (k == K_SPACE) begin
                    parse_state = PH_EXP_EOL;
                    ev = EV_COMMIT;
                end else if (k == K_EOL) begin
                    parse_state = PH_EXP_NAME;
                    ev = EV_COMMIT;
                end else if (k == K_HASH) begin
                    parse_state = PH_COMMENT;
                    ev = EV_COMMIT;
                end else begin
                    ev = EV_VAL_CHAR;
                    ob = b;
                end
            end
            PH_QUOTED: begin
                if (escape_q) begin
                    escape_q = 1'b0;
                    ev = EV_VAL_CHAR;
                    ob = b;
                end else if (k == K_QUOTE) begin
                    parse_state = PH_EXP_EOL;
                    ev = EV_COMMIT;
                end else if (k == K_ESC) begin
                    escape_q = 1'b1;
                end else begin
                    ev = EV_VAL_CHAR;
                    ob = b;
                end
            end
            PH_EXP_EOL: begin
                if (k == K_HASH) begin
                    parse_state = PH_COMMENT;
                end else if (k == K_EOL) begin
                    parse_state = PH_EXP_NAME;
                end else if (k != K_SPACE) begin
                    ev = EV_ERROR;
                    code = ERR_EOL_EXP;
                end
            end
            default: parse_state = PH_EXP_NAME;
        endcase
        r = token_word(ev, ob, code, line_q, col_q);
        if (ev == EV_ERROR) begin
            halt_q = 1'b1;
        end else if (b == CH_EOL) begin
            if (line_q < LINE_MAX) begin
                line_q = line_q + 1'b1;
            end
            col_q = '0;
        end
        return r;
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic eos);
        step_row_t row;
        row.b     = b;
        row.eos   = eos;
        row.fixed = 1'b0;
        row.res   = '0;
        directed_steps.push_back(row);
    endfunction

    function automatic void add_fixed(input logic [7:0] b, input logic eos,
                                      input logic [3:0] ev, input logic [2:0] code,
                                      input int unsigned ln, input int unsigned col);
        step_row_t row;
        row.b     = b;
        row.eos   = eos;
        row.fixed = 1'b1;
        row.res   = token_word(ev, 8'h00, code, LINE_FIELD_BITS'(ln),
                               COLUMN_FIELD_BITS'(col));
        directed_steps.push_back(row);
    endfunction

    // The expectation is queued at the edge where the word is taken, so it is
    // always ahead of the result that the word produces.
    task automatic send_word(input logic [7:0] b, input logic eos, input bit fixed,
                             input result_t typed);
        result_t r;
        while (!steady_run && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        r = tokenize_byte(b, eos);
        expected_tokens.push_back(fixed ? typed : r);
    endtask

    task automatic put(input logic [7:0] b, input logic eos);
        logic [7:0] w;
        w = b;
        if (!eos && $urandom_range(99) < noise_pct) begin
            w = 8'($urandom_range(255));
        end
        if (eos || !halt_q) begin
            live_words++;
        end
        steady_run = live_words >= 300 && live_words < 450;
        send_word(w, eos, 1'b0, '0);
    endtask

    function automatic logic [7:0] rand_word_char();
        logic [7:0] c;
        case ($urandom_range(3))
            0: c = 8'("a" + $urandom_range(25));
            1: c = 8'("A" + $urandom_range(25));
            2: c = 8'("0" + $urandom_range(9));
            default: c = $urandom_range(1) ? CH_DASH : CH_UNDER;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] rand_space();
        logic [7:0] c;
        case ($urandom_range(5))
            0: c = CH_TAB;
            1: c = CH_VT;
            2: c = CH_FF;
            3: c = CH_CR;
            default: c = CH_SPACE;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] rand_value_char();
        logic [7:0]  c;
        char_class_t k;
        do begin
            c = 8'($urandom_range(255));
            k = byte_kind(c);
        end while (k == K_SPACE || k == K_EOL || k == K_QUOTE || k == K_HASH);
        return c;
    endfunction

    function automatic logic [7:0] rand_comment_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (c == CH_EOL);
        return c;
    endfunction

    task automatic line_tail();
        repeat ($urandom_range(2)) put(rand_space(), 1'b0);
        if ($urandom_range(99) < 20) begin
            put(CH_HASH, 1'b0);
            repeat ($urandom_range(8)) put(rand_comment_char(), 1'b0);
        end
        put(CH_EOL, 1'b0);
    endtask

    task automatic random_line();
        int unsigned sel;
        logic [7:0]  c;
        sel = $urandom_range(99);
        noise_pct = ($urandom_range(99) < 12) ? 15 : 0;
        if (sel < 18) begin
            put(CH_OPEN, 1'b0);
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(1)) begin
                    c = 8'("a" + $urandom_range(25));
                end else begin
                    c = 8'("0" + $urandom_range(9));
                end
                put(c, 1'b0);
            end
            put(CH_CLOSE, 1'b0);
            line_tail();
        end else if (sel < 28) begin
            repeat ($urandom_range(2)) put(rand_space(), 1'b0);
            if ($urandom_range(1)) begin
                put(CH_HASH, 1'b0);
                repeat ($urandom_range(8)) put(rand_comment_char(), 1'b0);
            end
            put(CH_EOL, 1'b0);
        end else if (sel < 33) begin
            repeat ($urandom_range(1, 4)) put(8'($urandom_range(255)), 1'b0);
            put(CH_EOL, 1'b0);
        end else begin
            repeat ($urandom_range(1, 6)) put(rand_word_char(), 1'b0);
            if ($urandom_range(2) == 0) begin
                repeat ($urandom_range(1, 2)) put(rand_space(), 1'b0);
            end
            put(CH_EQ, 1'b0);
            if ($urandom_range(2) == 0) begin
                repeat ($urandom_range(1, 2)) put(rand_space(), 1'b0);
            end
            if ($urandom_range(99) < 40) begin
                put(CH_QUOTE, 1'b0);
                repeat ($urandom_range(8)) begin
                    c = 8'($urandom_range(255));
                    if (c == CH_QUOTE || c == CH_ESC || $urandom_range(9) == 0) begin
                        put(CH_ESC, 1'b0);
                    end
                    put(c, 1'b0);
                end
                if ($urandom_range(99) < 8) begin
                    put(8'($urandom_range(255)), 1'b1);
                    return;
                end
                put(CH_QUOTE, 1'b0);
            end else begin
                put(rand_word_char(), 1'b0);
                repeat ($urandom_range(6)) put(rand_value_char(), 1'b0);
                if ($urandom_range(99) < 8) begin
                    put(8'($urandom_range(255)), 1'b1);
                    return;
                end
            end
            line_tail();
        end
        if ($urandom_range(99) < (halt_q ? 70 : 5)) begin
            put(8'($urandom_range(255)), 1'b1);
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= steady_run || ($urandom_range(99) >= 28);
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tokens.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("Unexpected output word: event %0d data %h", m_tuser, m_tdata);
                end
            end else begin
                want = expected_tokens.pop_front();
                if (m_tuser !== want.event_res || m_tdata[7:0] !== want.out_byte ||
                    m_tdata[10:8] !== want.error_code ||
                    m_tdata[30:11] !== want.line_number ||
                    m_tdata[46:31] !== want.column_number) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $write("Mismatch: event %0d/%0d byte %h/%h code %0d/%0d",
                               want.event_res, m_tuser, want.out_byte, m_tdata[7:0],
                               want.error_code, m_tdata[10:8]);
                        $display(" line %0d/%0d col %0d/%0d",
                                 want.line_number, m_tdata[30:11],
                                 want.column_number, m_tdata[46:31]);
                    end
                end
            end
        end
    end

    initial begin
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        aresetn  <= 1'b0;
        parse_state = PH_EXP_NAME;
        escape_q    = 1'b0;
        halt_q      = 1'b0;
        line_q      = LINE_FIELD_BITS'(1);
        col_q       = '0;

        add_fixed(8'hFF, 1'b1, EV_NONE, ERR_NONE, 1, 0);
        add_fixed(CH_OPEN, 1'b0, EV_SEC_OPEN, ERR_NONE, 1, 1);
        add_row("a", 1'b0);
        add_row(CH_CLOSE, 1'b0);
        add_row(CH_HASH, 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(CH_EOL, 1'b0);
        add_row(CH_UNDER, 1'b0);
        add_row("Z", 1'b0);
        add_row(CH_TAB, 1'b0);
        add_row(CH_EQ, 1'b0);
        add_row(CH_QUOTE, 1'b0);
        add_row(CH_ESC, 1'b0);
        add_row(CH_QUOTE, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(CH_QUOTE, 1'b0);
        add_row(CH_EOL, 1'b0);
        add_row("k", 1'b0);
        add_row(CH_EQ, 1'b0);
        add_row(CH_DASH, 1'b0);
        add_fixed(CH_QUOTE, 1'b0, EV_ERROR, ERR_VALUE_EXP, 3, 4);
        add_fixed("x", 1'b0, EV_NONE, ERR_NONE, 3, 4);
        add_fixed(8'h00, 1'b1, EV_NONE, ERR_NONE, 3, 4);
        add_fixed(CH_QUOTE, 1'b0, EV_ERROR, ERR_NAME_EXP, 1, 1);
        add_fixed(8'h55, 1'b1, EV_NONE, ERR_NONE, 1, 1);
        add_row("v", 1'b0);
        add_row(CH_EQ, 1'b0);
        add_row(CH_QUOTE, 1'b0);
        add_fixed(8'hAA, 1'b1, EV_ERROR, ERR_OPEN_QUOTE, 1, 3);
        add_row("v", 1'b0);
        add_row(CH_EQ, 1'b0);
        add_row("1", 1'b0);
        add_fixed(8'h00, 1'b1, EV_COMMIT, ERR_NONE, 1, 3);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_steps[i]) begin
            send_word(directed_steps[i].b, directed_steps[i].eos,
                      directed_steps[i].fixed, directed_steps[i].res);
        end

        while (live_words < RANDOM_WORDS) begin
            random_line();
        end

        s_tvalid <= 1'b0;
        while (expected_tokens.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
